/* design/atme_pkg.sv */
// shared types, constants and helpers for the affine transform matrix engine
package atme_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int ACC_W     = TERM_W + 2;
    localparam int IDX_W     = 4;

    localparam logic signed [DATA_W-1:0] FX_ONE  = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] FX_ZERO = '0;
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // diagonal entries of a column-major 4x4 matrix
    localparam logic [IDX_W-1:0] IDX_D0 = 4'd0;
    localparam logic [IDX_W-1:0] IDX_D1 = 4'd5;
    localparam logic [IDX_W-1:0] IDX_D2 = 4'd10;
    localparam logic [IDX_W-1:0] IDX_D3 = 4'd15;
    // translation column, rows 0..2
    localparam logic [IDX_W-1:0] IDX_T0 = 4'd12;
    localparam logic [IDX_W-1:0] IDX_T1 = 4'd13;
    localparam logic [IDX_W-1:0] IDX_T2 = 4'd14;
    localparam logic [IDX_W-1:0] IDX_LAST = 4'd15;

    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_LOAD      = 3'd1,
        CMD_TRANSLATE = 3'd2,
        CMD_SCALE     = 3'd3,
        CMD_POINT     = 3'd4,
        CMD_DIRECTION = 3'd5
    } cmd_t;

    // control travelling alongside one multiply-accumulate term
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             fin;
        logic [IDX_W-1:0] dest;
    } mac_ctl_t;

    function automatic logic signed [DATA_W-1:0] ident_entry(input logic [IDX_W-1:0] idx);
        logic signed [DATA_W-1:0] v;
        v = FX_ZERO;
        if (idx == IDX_D0 || idx == IDX_D1 || idx == IDX_D2 || idx == IDX_D3)
        begin
            v = FX_ONE;
        end
        return v;
    endfunction

endpackage

/* design/atme_mac.sv */
// shared fixed-point multiply-accumulate unit with saturation
module atme_mac
    import atme_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 issue,
    input  logic signed [DATA_W-1:0] op_a,
    input  logic signed [DATA_W-1:0] op_b,
    output mac_ctl_t                 res,
    output logic signed [DATA_W-1:0] res_val
);

    mac_ctl_t                 a_ctl_reg, b_ctl_reg, c_ctl_reg, d_ctl_reg;
    logic signed [DATA_W-1:0] opa_reg, opb_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] rnd;
    logic [ACC_W-DATA_W:0]    hi;

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
            d_ctl_reg <= '0;
        end
        else
        begin
            a_ctl_reg <= issue;
            b_ctl_reg <= a_ctl_reg;
            c_ctl_reg <= b_ctl_reg;
            d_ctl_reg <= c_ctl_reg;
        end
    end

    // round toward zero: bias negative products before the shift
    assign rnd = prod_reg + PROD_W'({FRAC_BITS{prod_reg[PROD_W-1]}});

    always_comb
    begin
        acc_next = (c_ctl_reg.first ? ACC_W'(0) : acc_reg)
                 + {{(ACC_W-TERM_W){term_reg[TERM_W-1]}}, term_reg};
    end

    always_ff @(posedge clk)
    begin
        opa_reg  <= op_a;
        opb_reg  <= op_b;
        prod_reg <= opa_reg * opb_reg;
        term_reg <= rnd[PROD_W-1:FRAC_BITS];
        if (c_ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // saturate the finished sum to 32 bits
    assign hi = acc_reg[ACC_W-1:DATA_W-1];

    always_comb
    begin
        res       = d_ctl_reg;
        res.valid = d_ctl_reg.valid && d_ctl_reg.last;
        if ((&hi) || !(|hi))
        begin
            res_val = acc_reg[DATA_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            res_val = SAT_MIN;
        end
        else
        begin
            res_val = SAT_MAX;
        end
    end

endmodule

/* design/affine_transform_matrix_engine.sv */
// top level of the affine transform matrix engine: command sequencer and matrix storage
module affine_transform_matrix_engine
    import atme_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    output logic                     done,
    input  logic [2:0]               command,
    input  logic [IDX_W-1:0]         element_index,
    input  logic signed [DATA_W-1:0] value_a,
    input  logic signed [DATA_W-1:0] value_b,
    input  logic signed [DATA_W-1:0] value_c,
    output logic signed [DATA_W-1:0] out_x,
    output logic signed [DATA_W-1:0] out_y,
    output logic signed [DATA_W-1:0] out_z
);

    // a request is taken on a rising edge with start high and busy low. clear, and a load
    // of any index but 15, finish in that single cycle and leave busy low. every other
    // command runs on one shared pipelined multiply-accumulate unit (four register stages)
    // fed one term per cycle: transform point and transform direction issue twelve terms
    // (three rows of four, the fourth term carrying the translation or zero), stay busy
    // until the last row drains and raise a one-cycle done strobe with out_x, out_y, out_z
    // as busy falls, so a new request can be taken while done is shown; for translate,
    // scale and a load of index 15 the engine pre-multiplies the current matrix with 64
    // terms, drains the pipeline and copies the product across before busy falls. done
    // cannot be held off: the receiver must take the result in the cycle it is shown,
    // although the output ports keep the last transform until the next one. products are
    // rounded toward zero and each dot product saturates to 32 bits. the staging matrix
    // has no reset; reading an entry never loaded is outside the contract

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_COPY
    } state_t;

    // source of the left-hand matrix, or a vector transform
    typedef enum logic [1:0] {
        MODE_STAGE,
        MODE_TRANS,
        MODE_SCALE,
        MODE_XFORM
    } mode_t;

    state_t                   state_reg;
    mode_t                    mode_reg;
    logic [5:0]               cnt_reg;
    logic                     done_reg;
    logic signed [DATA_W-1:0] val_a_reg, val_b_reg, val_c_reg, w3_reg;
    logic signed [DATA_W-1:0] out_x_reg, out_y_reg, out_z_reg;

    logic signed [DATA_W-1:0] cur_reg   [16];   // current matrix, column-major
    logic signed [DATA_W-1:0] stage_mem [16];   // staging matrix
    logic signed [DATA_W-1:0] prod_mem  [16];   // premultiply result, copied at the end

    logic                     accept;
    cmd_t                     cmd;
    logic [1:0]               k, row, col;
    logic [IDX_W-1:0]         lhs_idx, m_idx;
    logic signed [DATA_W-1:0] m_rd, l_val, w_val;
    logic signed [DATA_W-1:0] op_a, op_b;
    mac_ctl_t                 issue, res;
    logic signed [DATA_W-1:0] res_val;

    assign accept = start && !busy;
    assign cmd    = cmd_t'(command);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign out_x  = out_x_reg;
    assign out_y  = out_y_reg;
    assign out_z  = out_z_reg;

    // operand selection for the term being issued: k is the inner index
    always_comb
    begin
        k       = cnt_reg[1:0];
        row     = cnt_reg[3:2];
        col     = cnt_reg[5:4];
        lhs_idx = {k, row};
        m_idx   = (mode_reg == MODE_XFORM) ? {k, row} : {col, k};
        m_rd    = cur_reg[m_idx];

        case (mode_reg)
            MODE_STAGE:
            begin
                l_val = stage_mem[lhs_idx];
            end
            MODE_TRANS:
            begin
                if (lhs_idx == IDX_T0)
                begin
                    l_val = val_a_reg;
                end
                else if (lhs_idx == IDX_T1)
                begin
                    l_val = val_b_reg;
                end
                else if (lhs_idx == IDX_T2)
                begin
                    l_val = val_c_reg;
                end
                else
                begin
                    l_val = ident_entry(lhs_idx);
                end
            end
            MODE_SCALE:
            begin
                if (lhs_idx == IDX_D0)
                begin
                    l_val = val_a_reg;
                end
                else if (lhs_idx == IDX_D1)
                begin
                    l_val = val_b_reg;
                end
                else if (lhs_idx == IDX_D2)
                begin
                    l_val = val_c_reg;
                end
                else
                begin
                    l_val = ident_entry(lhs_idx);
                end
            end
            default:
            begin
                l_val = FX_ZERO;
            end
        endcase

        case (k)
            2'd0:    w_val = val_a_reg;
            2'd1:    w_val = val_b_reg;
            2'd2:    w_val = val_c_reg;
            default: w_val = w3_reg;
        endcase

        if (mode_reg == MODE_XFORM)
        begin
            op_a       = m_rd;
            op_b       = w_val;
            issue.fin  = (row == 2'd2) && (k == 2'd3);
            issue.dest = {2'b00, row};
        end
        else
        begin
            op_a       = l_val;
            op_b       = m_rd;
            issue.fin  = (cnt_reg == 6'd63);
            issue.dest = {col, row};
        end
        issue.valid = (state_reg == ST_RUN);
        issue.first = (k == 2'd0);
        issue.last  = (k == 2'd3);
    end

    atme_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .op_a    (op_a),
        .op_b    (op_b),
        .res     (res),
        .res_val (res_val)
    );

    // staging matrix writes
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_LOAD)
        begin
            stage_mem[element_index] <= value_a;
        end
    end

    // premultiply results land here until the copy
    always_ff @(posedge clk)
    begin
        if (res.valid && mode_reg != MODE_XFORM)
        begin
            prod_mem[res.dest] <= res_val;
        end
    end

    // sequencer, current matrix and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_STAGE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            val_a_reg <= FX_ZERO;
            val_b_reg <= FX_ZERO;
            val_c_reg <= FX_ZERO;
            w3_reg    <= FX_ZERO;
            out_x_reg <= FX_ZERO;
            out_y_reg <= FX_ZERO;
            out_z_reg <= FX_ZERO;
            for (int i = 0; i < 16; i++)
            begin
                cur_reg[i] <= ident_entry(IDX_W'(i));
            end
        end
        else
        begin
            done_reg <= 1'b0;
            // rows 0 and 1 of a transform finish while terms are still being issued
            if (res.valid && mode_reg == MODE_XFORM)
            begin
                case (res.dest[1:0])
                    2'd0:    out_x_reg <= res_val;
                    2'd1:    out_y_reg <= res_val;
                    default: out_z_reg <= res_val;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                    begin
                        val_a_reg <= value_a;
                        val_b_reg <= value_b;
                        val_c_reg <= value_c;
                        case (cmd)
                            CMD_CLEAR:
                            begin
                                for (int i = 0; i < 16; i++)
                                begin
                                    cur_reg[i] <= ident_entry(IDX_W'(i));
                                end
                            end
                            CMD_LOAD:
                            begin
                                if (element_index == IDX_LAST)
                                begin
                                    mode_reg  <= MODE_STAGE;
                                    state_reg <= ST_RUN;
                                end
                            end
                            CMD_TRANSLATE:
                            begin
                                mode_reg  <= MODE_TRANS;
                                state_reg <= ST_RUN;
                            end
                            CMD_SCALE:
                            begin
                                mode_reg  <= MODE_SCALE;
                                state_reg <= ST_RUN;
                            end
                            CMD_POINT:
                            begin
                                mode_reg  <= MODE_XFORM;
                                w3_reg    <= FX_ONE;
                                state_reg <= ST_RUN;
                            end
                            CMD_DIRECTION:
                            begin
                                mode_reg  <= MODE_XFORM;
                                w3_reg    <= FX_ZERO;
                                state_reg <= ST_RUN;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_RUN:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (issue.fin)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (res.valid && res.fin)
                    begin
                        if (mode_reg == MODE_XFORM)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_COPY;
                        end
                    end
                end
                ST_COPY:
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        cur_reg[i] <= prod_mem[i];
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // the done strobe only follows the drain of a transform
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_DRAIN && state_reg == ST_IDLE))
        else $error("done without a finished transform");

    // no finished dot product may appear while the sequencer is idle or copying
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("mac result outside a command");

    // the matrix copy happens only after the last premultiply term drained
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COPY |-> ($past(state_reg) == ST_DRAIN && mode_reg != MODE_XFORM))
        else $error("matrix copy out of sequence");

    // issue counter never runs past a transform's twelve terms
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && mode_reg == MODE_XFORM) |-> (cnt_reg < 6'd12))
        else $error("transform issued too many terms");

endmodule
